// ----- sv/tfbs_pkg.sv -----
// Shared constants, types and helper functions for the three-frame background subtractor.
// No dependencies; the core and tfbs_score import this package.
package tfbs_pkg;

    localparam int ADDR_W     = 18;
    localparam int MAX_PIXELS = 1 << ADDR_W;
    localparam int HIST_W     = 16;

    localparam logic [ADDR_W-1:0] PIX_LAST = ADDR_W'(MAX_PIXELS - 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA_ENABLE = 1'b1;

    localparam logic [7:0] THRESHOLD_RESET = 8'd25;
    localparam logic [1:0] FRAMES_READY    = 2'd3;

    localparam logic [21:0] GRAY_WB    = 22'd1868;
    localparam logic [21:0] GRAY_WG    = 22'd9617;
    localparam logic [21:0] GRAY_WR    = 22'd4899;
    localparam logic [21:0] GRAY_ROUND = 22'd8192;

    localparam logic [17:0] BG_WCUR   = 18'd102;
    localparam logic [17:0] BG_WPREV  = 18'd205;
    localparam logic [17:0] BG_WBACK2 = 18'd717;
    localparam logic [17:0] BG_ROUND  = 18'd512;

    typedef logic [HIST_W-1:0] hist_t;

    typedef struct packed {
        logic       valid;
        logic       ok;
        logic       last;
        logic [7:0] cur;
        hist_t      hist;
    } gray_stage_t;

    typedef struct packed {
        logic       valid;
        logic       foreground;
        logic [7:0] background_level;
        logic       last_pixel;
    } result_t;

    // round(v*v/255); x/255 computed as (x + (x >> 8) + 1) >> 8, exact for x below 65535
    function automatic logic [7:0] gamma2(input logic [7:0] v);
        logic [16:0] x;
        logic [16:0] q;
        x = 17'(16'(v) * 16'(v)) + 17'd127;
        q = x + (x >> 8) + 17'd1;
        return q[15:8];
    endfunction

endpackage

// ----- sv/tfbs_pix_if.sv -----
// Input channel: one BGR pixel with its end-of-frame mark per transfer.
// No dependencies.
interface tfbs_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_end;

    modport source (output valid, output blue, output green, output red, output frame_end,
                    input ready);
    modport sink   (input valid, input blue, input green, input red, input frame_end,
                    output ready);
endinterface

// ----- sv/tfbs_res_if.sv -----
// Output channel: foreground flag, background level and frame-end echo per transfer.
// No dependencies.
interface tfbs_res_if;
    logic       valid;
    logic       ready;
    logic       foreground;
    logic [7:0] background_level;
    logic       last_pixel;

    modport source (output valid, output foreground, output background_level,
                    output last_pixel, input ready);
    modport sink   (input valid, input foreground, input background_level,
                    input last_pixel, output ready);
endinterface

// ----- sv/three_frame_background_subtractor_core.sv -----
// Top level: pixel intake, gamma and gray stages, gray history RAM with forwarding.
// Depends on tfbs_pkg, tfbs_pix_if, tfbs_res_if, tfbs_hist_ram, tfbs_score.
//
//   channel   direction  payload                                    transfer
//   pixel     in         blue, green, red, frame_end                valid & ready
//   result    out        foreground, background_level, last_pixel   valid & ready
//   config    in         write_index, write_data                    write_enable
//
// One pixel per cycle while results are taken; a pixel passes stages s1, s2, s3, s4 and the result register.
// The history RAM is read at intake and written from stage s2; younger reads of the
// same position take the pending value from the forwarding path.
// A stalled result register freezes every stage together; no RAM clearing pass after reset.
// Warm-up: foreground and background_level read 0 until three frame ends have passed.
module three_frame_background_subtractor_core (
    input  logic                           clk,
    input  logic                           rst_n,
    tfbs_pix_if.sink                       pixel,
    tfbs_res_if.source                     result,
    input  logic                           write_enable,
    input  logic [tfbs_pkg::CFG_IDX_W-1:0]  write_index,
    input  logic [tfbs_pkg::CFG_DATA_W-1:0] write_data
);
    import tfbs_pkg::*;

    logic [7:0]        threshold_reg;
    logic              gamma_enable_reg;
    logic [ADDR_W-1:0] pixel_index_reg;
    logic [1:0]        frames_seen_reg;

    logic              s1_valid_reg;
    logic              s1_ok_reg;
    logic              s1_last_reg;
    logic [7:0]        s1_blue_reg;
    logic [7:0]        s1_green_reg;
    logic [7:0]        s1_red_reg;
    logic [ADDR_W-1:0] s1_pos_reg;

    logic              s2_valid_reg;
    logic              s2_ok_reg;
    logic              s2_last_reg;
    logic [7:0]        s2_blue_reg;
    logic [7:0]        s2_green_reg;
    logic [7:0]        s2_red_reg;
    logic [ADDR_W-1:0] s2_pos_reg;
    hist_t             s2_hist_reg;

    logic              fw_valid_reg;
    logic [ADDR_W-1:0] fw_addr_reg;
    hist_t             fw_data_reg;

    gray_stage_t       s3_reg;
    gray_stage_t       s3_next;
    result_t           res;

    logic              adv;
    logic              accept;
    logic [ADDR_W-1:0] rd_addr;
    hist_t             rd_data;
    hist_t             hist_fw;
    logic              wr_en;
    hist_t             wr_data;
    logic [21:0]       gray_sum;
    logic [7:0]        cur_s2;

    assign adv          = !res.valid || result.ready;
    assign accept       = pixel.valid && adv;
    assign pixel.ready  = adv;

    assign result.valid            = res.valid;
    assign result.foreground       = res.foreground;
    assign result.background_level = res.background_level;
    assign result.last_pixel       = res.last_pixel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            gamma_enable_reg <= 1'b0;
        end
        else if (write_enable)
        begin
            case (write_index)
                CFG_THRESHOLD:    threshold_reg    <= write_data;
                CFG_GAMMA_ENABLE: gamma_enable_reg <= write_data[0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_index_reg <= '0;
            frames_seen_reg <= '0;
        end
        else if (accept)
        begin
            if (pixel.frame_end)
            begin
                pixel_index_reg <= '0;
                if (frames_seen_reg != FRAMES_READY)
                begin
                    frames_seen_reg <= frames_seen_reg + 2'd1;
                end
            end
            else
            begin
                pixel_index_reg <= (pixel_index_reg == PIX_LAST) ? '0
                                                                 : pixel_index_reg + ADDR_W'(1);
            end
        end
    end

    // read at the intake position, or re-read the held position while stalled
    assign rd_addr = adv ? pixel_index_reg : s1_pos_reg;

    always_comb
    begin
        gray_sum = 22'(s2_blue_reg) * GRAY_WB
                 + 22'(s2_green_reg) * GRAY_WG
                 + 22'(s2_red_reg) * GRAY_WR
                 + GRAY_ROUND;
        cur_s2   = gray_sum[21:14];
    end

    assign wr_en   = adv && s2_valid_reg;
    assign wr_data = {s2_hist_reg[7:0], cur_s2};

    tfbs_hist_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (HIST_W)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (s2_pos_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // forward pending write first, then the write that landed with the last read
    always_comb
    begin
        if (s2_valid_reg && (s2_pos_reg == s1_pos_reg))
        begin
            hist_fw = wr_data;
        end
        else if (fw_valid_reg && (fw_addr_reg == s1_pos_reg))
        begin
            hist_fw = fw_data_reg;
        end
        else
        begin
            hist_fw = rd_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_valid_reg <= 1'b0;
        end
        else
        begin
            fw_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        fw_addr_reg <= s2_pos_reg;
        fw_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pixel.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_comb
    begin
        s3_next.valid = s2_valid_reg;
        s3_next.ok    = s2_ok_reg;
        s3_next.last  = s2_last_reg;
        s3_next.cur   = cur_s2;
        s3_next.hist  = s2_hist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_reg <= '0;
        end
        else if (adv)
        begin
            s3_reg <= s3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ok_reg    <= (frames_seen_reg == FRAMES_READY);
            s1_last_reg  <= pixel.frame_end;
            s1_blue_reg  <= pixel.blue;
            s1_green_reg <= pixel.green;
            s1_red_reg   <= pixel.red;
            s1_pos_reg   <= pixel_index_reg;

            s2_ok_reg    <= s1_ok_reg;
            s2_last_reg  <= s1_last_reg;
            s2_blue_reg  <= gamma_enable_reg ? gamma2(s1_blue_reg) : s1_blue_reg;
            s2_green_reg <= gamma_enable_reg ? gamma2(s1_green_reg) : s1_green_reg;
            s2_red_reg   <= gamma_enable_reg ? gamma2(s1_red_reg) : s1_red_reg;
            s2_pos_reg   <= s1_pos_reg;
            s2_hist_reg  <= hist_fw;
        end
    end

    tfbs_score u_score (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .gray_in   (s3_reg),
        .threshold (threshold_reg),
        .res       (res)
    );

endmodule

// ----- sv/tfbs_hist_ram.sv -----
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the per-position gray history; no package dependency.
module tfbs_hist_ram #(
    parameter int ADDR_W = 18,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/tfbs_score.sv -----
// Background weighting, threshold compare and output register.
// Depends on tfbs_pkg.
module tfbs_score (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  tfbs_pkg::gray_stage_t gray_in,
    input  logic [7:0]           threshold,
    output tfbs_pkg::result_t    res
);
    import tfbs_pkg::*;

    logic [17:0] bg_sum;
    logic [7:0]  bg_comb;

    logic       s4_valid_reg;
    logic       s4_ok_reg;
    logic       s4_last_reg;
    logic [7:0] s4_cur_reg;
    logic [7:0] s4_bg_reg;

    logic [7:0] diff;
    result_t    res_reg;
    result_t    res_next;

    always_comb
    begin
        bg_sum = 18'(gray_in.cur) * BG_WCUR
               + 18'(gray_in.hist[7:0]) * BG_WPREV
               + 18'(gray_in.hist[15:8]) * BG_WBACK2
               + BG_ROUND;
        bg_comb = bg_sum[17:10];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_valid_reg <= gray_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ok_reg   <= gray_in.ok;
            s4_last_reg <= gray_in.last;
            s4_cur_reg  <= gray_in.cur;
            s4_bg_reg   <= bg_comb;
        end
    end

    always_comb
    begin
        diff = (s4_cur_reg > s4_bg_reg) ? (s4_cur_reg - s4_bg_reg) : (s4_bg_reg - s4_cur_reg);
        res_next.valid            = s4_valid_reg;
        res_next.foreground       = s4_ok_reg && (diff > threshold);
        res_next.background_level = s4_ok_reg ? s4_bg_reg : 8'd0;
        res_next.last_pixel       = s4_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule
